### hdl/srdp_pkg.sv
// Shared types and constants for the sparse row dot product block.
`timescale 1ns / 1ps

package srdp_pkg;

    localparam int COL_W  = 10;
    localparam int VAL_W  = 32;
    localparam int ROW_W  = 16;
    localparam int SUM_W  = 48;
    localparam int PROD_W = 64;
    localparam int FRAC_W = 16;

    // The column and row residues are reduced in two halves, one in the front
    // and one in the back; these are the bit positions where they split.
    localparam int COL_SPLIT = 5;
    localparam int ROW_SPLIT = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic signed [SUM_W-1:0] ACC_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_NONZERO = 2'd1,
        REQ_EMPTY   = 2'd2
    } srdp_kind_t;

    typedef struct packed {
        srdp_kind_t               kind;
        logic [COL_W-1:0]         col;
        logic signed [VAL_W-1:0]  value;
        logic [ROW_W-1:0]         row;
        logic                     last;
    } srdp_item_t;

endpackage

### hdl/srdp_if.sv
// Valid/ready channel interfaces for requests and row results.
`timescale 1ns / 1ps

interface srdp_req_if;
    import srdp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              req_type;
    logic [COL_W-1:0]        col_index;
    logic signed [VAL_W-1:0] elem_value;
    logic [ROW_W-1:0]        row_index;
    logic                    row_last;

    modport source (
        output valid, req_type, col_index, elem_value, row_index, row_last,
        input  ready
    );
    modport sink (
        input  valid, req_type, col_index, elem_value, row_index, row_last,
        output ready
    );
endinterface

interface srdp_res_if;
    import srdp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ROW_W-1:0]        out_row;
    logic signed [SUM_W-1:0] row_sum;
    logic                    sum_saturated;

    modport source (
        output valid, out_row, row_sum, sum_saturated,
        input  ready
    );
    modport sink (
        input  valid, out_row, row_sum, sum_saturated,
        output ready
    );
endinterface

### hdl/srdp_front.sv
// Front end: accepts requests, drops unused types and starts index reduction.
`timescale 1ns / 1ps

module srdp_front #(
    parameter int VEC_DEPTH = 1024,
    parameter int MAX_ROWS  = 65536
) (
    srdp_req_if.sink            req,
    input  logic                q_full,
    output logic                q_push,
    output srdp_pkg::srdp_item_t q_item
);
    import srdp_pkg::*;

    logic             keep;
    logic [COL_W-1:0] col_part;
    logic [ROW_W-1:0] row_part;

    always_comb
    begin
        unique case (req.req_type)
            REQ_LOAD, REQ_NONZERO, REQ_EMPTY: keep = 1'b1;
            default:                          keep = 1'b0;
        endcase
    end

    // Upper steps of a restoring modulo; the back end finishes the rest.
    always_comb
    begin
        col_part = req.col_index;
        for (int k = COL_W - 1; k >= COL_SPLIT; k--)
        begin
            if ((longint'(VEC_DEPTH) << k) < (longint'(1) << COL_W))
            begin
                if (longint'(col_part) >= (longint'(VEC_DEPTH) << k))
                begin
                    col_part = col_part - COL_W'(longint'(VEC_DEPTH) << k);
                end
            end
        end
    end

    always_comb
    begin
        row_part = req.row_index;
        for (int k = ROW_W - 1; k >= ROW_SPLIT; k--)
        begin
            if ((longint'(MAX_ROWS) << k) < (longint'(1) << ROW_W))
            begin
                if (longint'(row_part) >= (longint'(MAX_ROWS) << k))
                begin
                    row_part = row_part - ROW_W'(longint'(MAX_ROWS) << k);
                end
            end
        end
    end

    assign req.ready = !q_full;
    assign q_push    = req.valid && !q_full && keep;

    always_comb
    begin
        q_item.kind  = srdp_kind_t'(req.req_type);
        q_item.col   = col_part;
        q_item.value = req.elem_value;
        q_item.row   = row_part;
        q_item.last  = req.row_last;
    end

endmodule

### hdl/srdp_fifo.sv
// Short register queue between the front end and the back end.
`timescale 1ns / 1ps

module srdp_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  srdp_pkg::srdp_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output srdp_pkg::srdp_item_t head_item
);
    import srdp_pkg::*;

    srdp_item_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic [PTR_W:0]     count_next;

    assign full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/srdp_back.sv
// Back end: vector store, multiply, saturating accumulate and result register.
`timescale 1ns / 1ps

module srdp_back #(
    parameter int VEC_DEPTH = 1024,
    parameter int MAX_ROWS  = 65536
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  srdp_pkg::srdp_item_t head_item,
    output logic                 pop,
    srdp_res_if.source           res
);
    import srdp_pkg::*;

    localparam int MEM_DEPTH = (VEC_DEPTH >= (1 << COL_W)) ? (1 << COL_W) : VEC_DEPTH;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic                     en;
    logic [COL_W-1:0]         col_red;
    logic [AW-1:0]            addr;

    logic signed [VAL_W-1:0]  x_mem [MEM_DEPTH];
    logic signed [VAL_W-1:0]  x_rd_reg;

    logic                     s1_valid_reg;
    srdp_kind_t               s1_kind_reg;
    logic signed [VAL_W-1:0]  s1_value_reg;
    logic [ROW_W-1:0]         s1_row_reg;
    logic                     s1_last_reg;

    logic                     s2_valid_reg;
    srdp_kind_t               s2_kind_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic [ROW_W-1:0]         s2_row_reg;
    logic                     s2_last_reg;

    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  acc_next;
    logic                     flag_reg;
    logic                     flag_next;

    logic signed [SUM_W-1:0]  term;
    logic signed [SUM_W:0]    sum_wide;
    logic                     ovf;
    logic signed [SUM_W-1:0]  sum_sat;
    logic                     flag_upd;
    logic [ROW_W-1:0]         row_red;
    logic                     emit;

    logic                     out_valid_reg;
    logic [ROW_W-1:0]         out_row_reg;
    logic signed [SUM_W-1:0]  out_sum_reg;
    logic                     out_sat_reg;

    // The whole back end holds while a result waits at the output.
    assign en  = !(out_valid_reg && !res.ready);
    assign pop = en && head_valid;

    // Lower steps of the column modulo.
    always_comb
    begin
        col_red = head_item.col;
        for (int k = COL_SPLIT - 1; k >= 0; k--)
        begin
            if ((longint'(VEC_DEPTH) << k) < (longint'(1) << COL_W))
            begin
                if (longint'(col_red) >= (longint'(VEC_DEPTH) << k))
                begin
                    col_red = col_red - COL_W'(longint'(VEC_DEPTH) << k);
                end
            end
        end
    end

    assign addr = col_red[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (head_item.kind == REQ_LOAD)
            begin
                x_mem[addr] <= head_item.value;
            end
            x_rd_reg <= x_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= pop && (head_item.kind != REQ_LOAD);
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_kind_reg  <= head_item.kind;
            s1_value_reg <= head_item.value;
            s1_row_reg   <= head_item.row;
            s1_last_reg  <= head_item.last;
            s2_kind_reg  <= s1_kind_reg;
            s2_prod_reg  <= s1_value_reg * x_rd_reg;
            s2_row_reg   <= s1_row_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // Dropping the low fraction bits of a two's complement product floors it.
    assign term     = s2_prod_reg[FRAC_W +: SUM_W];
    assign sum_wide = {acc_reg[SUM_W-1], acc_reg} + {term[SUM_W-1], term};
    assign ovf      = sum_wide[SUM_W] ^ sum_wide[SUM_W-1];
    assign sum_sat  = ovf ? (sum_wide[SUM_W] ? ACC_MIN : ACC_MAX) : sum_wide[SUM_W-1:0];
    assign flag_upd = flag_reg | ovf;

    always_comb
    begin
        row_red = s2_row_reg;
        for (int k = ROW_SPLIT - 1; k >= 0; k--)
        begin
            if ((longint'(MAX_ROWS) << k) < (longint'(1) << ROW_W))
            begin
                if (longint'(row_red) >= (longint'(MAX_ROWS) << k))
                begin
                    row_red = row_red - ROW_W'(longint'(MAX_ROWS) << k);
                end
            end
        end
    end

    assign emit = s2_valid_reg &&
                  ((s2_kind_reg == REQ_EMPTY) || ((s2_kind_reg == REQ_NONZERO) && s2_last_reg));

    always_comb
    begin
        acc_next  = acc_reg;
        flag_next = flag_reg;
        if (s2_valid_reg && (s2_kind_reg == REQ_NONZERO))
        begin
            if (s2_last_reg)
            begin
                acc_next  = '0;
                flag_next = 1'b0;
            end
            else
            begin
                acc_next  = sum_sat;
                flag_next = flag_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            acc_reg       <= acc_next;
            flag_reg      <= flag_next;
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_row_reg <= row_red;
            out_sum_reg <= (s2_kind_reg == REQ_EMPTY) ? '0 : sum_sat;
            out_sat_reg <= (s2_kind_reg == REQ_EMPTY) ? 1'b0 : flag_upd;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.out_row       = out_row_reg;
    assign res.row_sum       = out_sum_reg;
    assign res.sum_saturated = out_sat_reg;

endmodule

### hdl/sparse_row_dot_product.sv
// Top level of the sparse row dot product block.
`timescale 1ns / 1ps
// Throughput: one item per cycle while no result waits at the output, set by the saturating
// accumulate stage and the one-read, one-write port of the vector store.
// Reset clears the queue, pipeline valid bits, accumulator, overflow flag and output
// valid bit; the vector store is not cleared and holds garbage until loaded.

module sparse_row_dot_product #(
    parameter int VEC_DEPTH = 1024,
    parameter int MAX_ROWS  = 65536
) (
    input  logic       clk,
    input  logic       rst_n,
    srdp_req_if.sink   req,
    srdp_res_if.source rsp
);
    import srdp_pkg::*;

    // The front end accepts a request whenever the queue has room, throws away
    // transfers of the unused request type, and does the upper half of the
    // column and row modulo reductions so the back end only finishes them.
    logic       q_full;
    logic       q_push;
    srdp_item_t q_item;

    // Queue head as seen by the back end.
    logic       head_valid;
    srdp_item_t head_item;
    logic       pop;

    srdp_front #(
        .VEC_DEPTH (VEC_DEPTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_front (
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_item)
    );

    // A short queue decouples the two sides so that input transfers continue
    // while a finished result waits for the sink.
    srdp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // The back end writes vector loads into the store, reads the store for
    // nonzeros, multiplies, floors to Q32.16 and accumulates with saturation.
    // The last nonzero of a row, or an empty-row marker, produces a result
    // in the output register.
    srdp_back #(
        .VEC_DEPTH (VEC_DEPTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .res        (rsp)
    );

endmodule

### tb/sv/sparse_row_dot_product_tb.sv
// Self-checking testbench for the sparse row dot product block.
`timescale 1ns / 1ps

module sparse_row_dot_product_tb;
    import srdp_pkg::*;

    // The block has no name for the fourth request code; it must be ignored.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int ITEM_TARGET  = 500;
    localparam int IDLE_PERCENT = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 12;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [1:0]              kind;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic [ROW_W-1:0]        row;
        logic                    last;
    } req_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic signed [SUM_W-1:0] sum;
        logic                    sat;
    } row_result_t;

    typedef struct packed {
        req_item_t   item;
        logic        typed;
        row_result_t res;
    } dir_row_t;

    localparam int DIR_COUNT = 23;

    // Directed table: kind, column, value, row, last; then whether the result is
    // typed in here, and the typed result. Untyped rows go through the predictor.
    localparam dir_row_t DIRECTED_ROWS [DIR_COUNT] = '{
        // Loads ignore the row and last fields.
        '{'{REQ_LOAD,    10'd0,    32'h0001_0000, 16'hFFFF, 1'b1}, 1'b0, '0},
        '{'{REQ_LOAD,    10'd1023, 32'h7FFF_FFFF, 16'h0000, 1'b0}, 1'b0, '0},
        '{'{REQ_LOAD,    10'd1,    32'h8000_0000, 16'h0000, 1'b0}, 1'b0, '0},
        '{'{REQ_LOAD,    10'd2,    32'hFFFF_FFFF, 16'h0000, 1'b0}, 1'b0, '0},
        // Empty rows at both ends of the row range.
        '{'{REQ_EMPTY,   10'd0,    32'h0000_0000, 16'h0000, 1'b0}, 1'b1,
          '{16'h0000, 48'sd0, 1'b0}},
        '{'{REQ_EMPTY,   10'd1023, 32'hFFFF_FFFF, 16'hFFFF, 1'b1}, 1'b1,
          '{16'hFFFF, 48'sd0, 1'b0}},
        '{'{REQ_UNUSED,  10'd0,    32'h0000_1234, 16'h0007, 1'b1}, 1'b0, '0},
        // One times one is one.
        '{'{REQ_NONZERO, 10'd0,    32'h0001_0000, 16'h0005, 1'b1}, 1'b1,
          '{16'h0005, 48'sh0000_0001_0000, 1'b0}},
        // Two products of the most negative values push past the top.
        '{'{REQ_NONZERO, 10'd1,    32'h8000_0000, 16'h0006, 1'b0}, 1'b0, '0},
        '{'{REQ_NONZERO, 10'd1,    32'h8000_0000, 16'h0006, 1'b1}, 1'b1,
          '{16'h0006, ACC_MAX, 1'b1}},
        // Three large negative products push past the bottom.
        '{'{REQ_NONZERO, 10'd1023, 32'h8000_0000, 16'h0007, 1'b0}, 1'b0, '0},
        '{'{REQ_NONZERO, 10'd1023, 32'h8000_0000, 16'h0007, 1'b0}, 1'b0, '0},
        '{'{REQ_NONZERO, 10'd1023, 32'h8000_0000, 16'h0007, 1'b1}, 1'b1,
          '{16'h0007, ACC_MIN, 1'b1}},
        // Accumulation continues from the clamped value, flag stays set.
        '{'{REQ_NONZERO, 10'd1,    32'h8000_0000, 16'h0008, 1'b0}, 1'b0, '0},
        '{'{REQ_NONZERO, 10'd1,    32'h8000_0000, 16'h0008, 1'b0}, 1'b0, '0},
        '{'{REQ_NONZERO, 10'd1023, 32'h8000_0000, 16'h0008, 1'b1}, 1'b0, '0},
        // A tiny negative product rounds toward minus infinity.
        '{'{REQ_NONZERO, 10'd2,    32'h0000_0001, 16'h0009, 1'b1}, 1'b0, '0},
        // An empty marker and an ignored code inside an unfinished row.
        '{'{REQ_NONZERO, 10'd0,    32'h0002_0000, 16'h000A, 1'b0}, 1'b0, '0},
        '{'{REQ_EMPTY,   10'd0,    32'h0000_0000, 16'h000B, 1'b0}, 1'b1,
          '{16'h000B, 48'sd0, 1'b0}},
        '{'{REQ_UNUSED,  10'd1023, 32'hFFFF_FFFF, 16'hFFFF, 1'b1}, 1'b0, '0},
        '{'{REQ_NONZERO, 10'd0,    32'h0003_0000, 16'h000C, 1'b1}, 1'b0, '0},
        // A zero vector entry gives a zero row.
        '{'{REQ_LOAD,    10'd1023, 32'h0000_0000, 16'h1234, 1'b1}, 1'b0, '0},
        '{'{REQ_NONZERO, 10'd1023, 32'h7FFF_FFFF, 16'h000D, 1'b1}, 1'b1,
          '{16'h000D, 48'sd0, 1'b0}}
    };

    logic clk;
    logic rst_n;

    srdp_req_if req ();
    srdp_res_if rsp ();

    sparse_row_dot_product dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Mirror of the block's state, updated at every accepted request.
    logic [VAL_W-1:0]        x_copy [2**COL_W];
    logic signed [SUM_W-1:0] acc_copy;
    logic                    flag_copy;

    // Columns whose vector entry has been loaded; nonzeros only read these.
    bit                      col_loaded [2**COL_W];
    int                      loaded_cols [$];

    row_result_t             sum_queue [$];
    int                      sent_items;
    int                      error_count;
    int                      stall_request;
    bit                      src_quiet;
    bit                      snk_quiet;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("sparse_row_dot_product_tb NOT OK");
        $finish;
    end

    // Advances the mirrored state by one request. Returns 1 when the request
    // closes a row or marks an empty one, with the row result in res.
    function automatic bit dot_step(input req_item_t it, output row_result_t res);
        logic signed [63:0] a;
        logic signed [63:0] x;
        logic signed [63:0] prod;
        logic signed [63:0] total;
        logic signed [63:0] hi_lim;
        logic signed [63:0] lo_lim;
        res    = '0;
        hi_lim = ACC_MAX;
        lo_lim = ACC_MIN;
        if (it.kind == REQ_LOAD)
        begin
            x_copy[it.col] = it.value;
            return 1'b0;
        end
        if (it.kind == REQ_EMPTY)
        begin
            res.row = it.row;
            return 1'b1;
        end
        if (it.kind != REQ_NONZERO)
            return 1'b0;

        a     = {{32{it.value[VAL_W-1]}}, it.value};
        x     = {{32{x_copy[it.col][VAL_W-1]}}, x_copy[it.col]};
        prod  = a * x;
        total = {{16{acc_copy[SUM_W-1]}}, acc_copy};
        // The arithmetic shift drops the low fraction bits with floor rounding.
        total = total + (prod >>> FRAC_W);
        if (total > hi_lim)
        begin
            total     = hi_lim;
            flag_copy = 1'b1;
        end
        else if (total < lo_lim)
        begin
            total     = lo_lim;
            flag_copy = 1'b1;
        end
        acc_copy = total[SUM_W-1:0];
        if (!it.last)
            return 1'b0;
        res.row   = it.row;
        res.sum   = acc_copy;
        res.sat   = flag_copy;
        acc_copy  = '0;
        flag_copy = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        unique case ($urandom_range(3))
            0:
            begin
                unique case ($urandom_range(4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0001_0000;
                endcase
            end
            1:       return 32'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] pick_row();
        unique case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return ROW_W'($urandom());
        endcase
    endfunction

    // Offers one request, waits for its transfer and records the expected result.
    task automatic send_request(input req_item_t it, input bit typed,
                                input row_result_t typed_res);
        row_result_t res;
        bit          has_res;
        while (!src_quiet && $urandom_range(99) < IDLE_PERCENT)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.req_type   <= it.kind;
        req.col_index  <= it.col;
        req.elem_value <= it.value;
        req.row_index  <= it.row;
        req.row_last   <= it.last;
        do
            @(posedge clk);
        while (!req.ready);

        if (it.kind == REQ_LOAD && !col_loaded[it.col])
        begin
            col_loaded[it.col] = 1'b1;
            loaded_cols = {loaded_cols, int'(it.col)};
        end
        has_res = dot_step(it, res);
        if (has_res)
            sum_queue = {sum_queue, (typed ? typed_res : res)};
        if (it.kind != REQ_UNUSED)
            sent_items++;
    endtask

    // Result side: checks every transfer against the oldest expectation and
    // decides ready for the next cycle, including the long hold-off.
    initial
    begin : result_side
        row_result_t want;
        int          hold_left;
        hold_left  = 0;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                if (sum_queue.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("unexpected result: row %0h sum %0h sat %0b",
                                 rsp.out_row, rsp.row_sum, rsp.sum_saturated);
                end
                else
                begin
                    want = sum_queue.pop_front();
                    if (rsp.out_row !== want.row || rsp.row_sum !== want.sum
                        || rsp.sum_saturated !== want.sat)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("row result mismatch: expected row %0h sum %0h sat %0b, %s",
                                     want.row, want.sum, want.sat, "see actual below");
                        if (error_count <= REPORT_LIMIT)
                            $display("  actual row %0h sum %0h sat %0b",
                                     rsp.out_row, rsp.row_sum, rsp.sum_saturated);
                    end
                end
            end
            if (stall_request > 0)
            begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= snk_quiet || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial
    begin : request_side
        req_item_t it;
        int        sel;
        int        n;
        int        drain_wait;
        bit        stall_done;
        bit        pause_done;
        logic [ROW_W-1:0] r;

        sent_items     = 0;
        error_count    = 0;
        stall_request  = 0;
        src_quiet      = 1'b0;
        snk_quiet      = 1'b0;
        stall_done     = 1'b0;
        pause_done     = 1'b0;
        acc_copy       = '0;
        flag_copy      = 1'b0;
        rst_n          <= 1'b0;
        req.valid      <= 1'b0;
        req.req_type   <= REQ_LOAD;
        req.col_index  <= '0;
        req.elem_value <= '0;
        req.row_index  <= '0;
        req.row_last   <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_COUNT; i++)
            send_request(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);

        // Random part: mostly complete rows over loaded columns, with loads,
        // empty markers, ignored codes and rows left open in between.
        while (sent_items < ITEM_TARGET)
        begin
            if (!stall_done && sent_items >= 150)
            begin
                // The result side holds off while requests keep coming.
                stall_done    = 1'b1;
                stall_request = HOLD_CYCLES;
                src_quiet     = 1'b1;
            end
            if (stall_done && sent_items >= 200 && sent_items < 350)
                src_quiet = 1'b0;
            if (!pause_done && sent_items >= 300)
            begin
                // Let the block drain completely before going on, with the valid
                // line held low while it drains.
                pause_done = 1'b1;
                req.valid <= 1'b0;
                do
                    @(posedge clk);
                while (sum_queue.size() != 0);
            end
            // A stretch with no idling on either side; the source also does not idle from the hold-off to item 200.
            src_quiet = (sent_items >= 350 && sent_items < 450) ||
                        (stall_done && sent_items < 200);
            snk_quiet = (sent_items >= 350 && sent_items < 450);

            sel = $urandom_range(99);
            if (sel < 60)
            begin
                n = $urandom_range(1, 6);
                r = pick_row();
                for (int k = 0; k < n; k++)
                begin
                    it.kind  = REQ_NONZERO;
                    it.col   = COL_W'(loaded_cols[$urandom_range(loaded_cols.size() - 1)]);
                    it.value = pick_value();
                    it.row   = r;
                    it.last  = (k == n - 1);
                    send_request(it, 1'b0, '0);
                end
            end
            else if (sel < 78)
            begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                begin
                    it.kind  = REQ_LOAD;
                    it.col   = COL_W'($urandom());
                    it.value = pick_value();
                    it.row   = ROW_W'($urandom());
                    it.last  = 1'($urandom());
                    send_request(it, 1'b0, '0);
                end
            end
            else if (sel < 88)
            begin
                it.kind  = REQ_EMPTY;
                it.col   = COL_W'($urandom());
                it.value = $urandom();
                it.row   = pick_row();
                it.last  = 1'($urandom());
                send_request(it, 1'b0, '0);
            end
            else if (sel < 94)
            begin
                it.kind  = REQ_UNUSED;
                it.col   = COL_W'($urandom());
                it.value = $urandom();
                it.row   = ROW_W'($urandom());
                it.last  = 1'($urandom());
                send_request(it, 1'b0, '0);
            end
            else
            begin
                // A row left open, interrupted by an empty marker.
                it.kind  = REQ_NONZERO;
                it.col   = COL_W'(loaded_cols[$urandom_range(loaded_cols.size() - 1)]);
                it.value = pick_value();
                it.row   = pick_row();
                it.last  = 1'b0;
                send_request(it, 1'b0, '0);
                it.kind  = REQ_EMPTY;
                it.row   = pick_row();
                it.last  = 1'($urandom());
                send_request(it, 1'b0, '0);
            end
        end

        req.valid <= 1'b0;
        drain_wait = 0;
        while (sum_queue.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        if (sum_queue.size() != 0)
        begin
            error_count++;
            $display("%0d row results never arrived", sum_queue.size());
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("sparse_row_dot_product_tb OK");
        else
            $display("sparse_row_dot_product_tb NOT OK");
        $finish;
    end

endmodule
